// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the frame header parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RFHP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
`define RFHP_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define RFHP_ASSERT(lbl, clk, rstn, prop)
`define RFHP_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ----- rtl/rfhp_pkg.sv -----
// Package: types, constants and helper functions of the frame header parser.
`timescale 1ns / 1ps

package rfhp_pkg;

  localparam int unsigned RFHP_QUEUE_DEPTH = 4;

  typedef enum logic [3:0] {
    PH_FLAGS = 4'd0,
    PH_LEN   = 4'd1,
    PH_MIDX  = 4'd2,
    PH_OIDX  = 4'd3,
    PH_OCH   = 4'd4,
    PH_SCNT  = 4'd5,
    PH_SID   = 4'd6,
    PH_SIDX  = 4'd7,
    PH_PAY   = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HDR = 2'd0,
    KIND_PAY = 2'd1,
    KIND_ERR = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  reliability;
    logic        has_split;
    logic [13:0] payload_length;
    logic [23:0] message_index;
    logic [23:0] order_index;
    logic [7:0]  order_channel;
    logic [31:0] split_count;
    logic [15:0] split_id;
    logic [31:0] split_index;
    logic [7:0]  payload_byte;
    logic        last_byte;
  } result_t;

  typedef struct packed {
    logic    prim_vld;
    logic    err;
    result_t rslt;
  } entry_t;

  function automatic logic [2:0] section_len(phase_e ph);
    logic [2:0] n;
    unique case (ph)
      PH_FLAGS: n = 3'd1;
      PH_LEN:   n = 3'd2;
      PH_MIDX:  n = 3'd3;
      PH_OIDX:  n = 3'd3;
      PH_OCH:   n = 3'd1;
      PH_SCNT:  n = 3'd4;
      PH_SID:   n = 3'd2;
      PH_SIDX:  n = 3'd4;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic has_midx(logic [2:0] rel);
    return (rel == 3'd2) || (rel == 3'd3) || (rel == 3'd4) || (rel == 3'd6) ||
           (rel == 3'd7);
  endfunction

  function automatic logic has_order(logic [2:0] rel);
    return (rel == 3'd1) || (rel == 3'd3) || (rel == 3'd4) || (rel == 3'd7);
  endfunction

  function automatic phase_e next_phase(phase_e ph, logic [2:0] rel, logic split);
    phase_e after_split;
    phase_e after_midx;
    phase_e nxt;
    after_split = split ? PH_SCNT : PH_PAY;
    after_midx  = has_order(rel) ? PH_OIDX : after_split;
    unique case (ph)
      PH_FLAGS: nxt = PH_LEN;
      PH_LEN:   nxt = has_midx(rel) ? PH_MIDX : after_midx;
      PH_MIDX:  nxt = after_midx;
      PH_OIDX:  nxt = PH_OCH;
      PH_OCH:   nxt = after_split;
      PH_SCNT:  nxt = PH_SID;
      PH_SID:   nxt = PH_SIDX;
      default:  nxt = PH_PAY;
    endcase
    return nxt;
  endfunction

endpackage

// ----- rtl/rfhp_front.sv -----
// Front end: accepts datagram bytes, tracks frame fields, posts result entries.
`timescale 1ns / 1ps

module rfhp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       data_byte_i,
  input  logic             datagram_end_i,
  input  logic             q_full_i,
  output logic             push_o,
  output rfhp_pkg::entry_t entry_o,
  output rfhp_pkg::phase_e phase_o
);

  rfhp_pkg::phase_e phase_q, phase_d, ph_cur;
  logic [2:0]  cnt_q, cnt_d, cnt_inc;
  logic [2:0]  rel_q, rel_d;
  logic        split_q, split_d;
  logic [15:0] len_q, len_d;
  logic [23:0] midx_q, midx_d;
  logic [23:0] oidx_q, oidx_d;
  logic [7:0]  och_q, och_d;
  logic [31:0] scnt_q, scnt_d;
  logic [15:0] sid_q, sid_d;
  logic [31:0] sidx_q, sidx_d;
  logic [13:0] rem_q, rem_d;
  logic [16:0] len_round;
  logic [4:0]  shamt;
  logic        accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign phase_o    = phase_q;
  assign cnt_inc    = cnt_q + 3'd1;
  assign shamt      = {cnt_q[1:0], 3'b000};
  assign ph_cur     = (phase_q > rfhp_pkg::PH_PAY) ? rfhp_pkg::PH_FLAGS : phase_q;

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    rel_d     = rel_q;
    split_d   = split_q;
    len_d     = len_q;
    midx_d    = midx_q;
    oidx_d    = oidx_q;
    och_d     = och_q;
    scnt_d    = scnt_q;
    sid_d     = sid_q;
    sidx_d    = sidx_q;
    rem_d     = rem_q;
    len_round = 17'd0;
    entry_o   = '0;
    if (accept) begin
      if (ph_cur == rfhp_pkg::PH_PAY) begin
        rem_d                        = rem_q - 14'd1;
        entry_o.prim_vld             = 1'b1;
        entry_o.rslt.kind            = rfhp_pkg::KIND_PAY;
        entry_o.rslt.payload_byte    = data_byte_i;
        entry_o.rslt.last_byte       = (rem_d == 14'd0);
        phase_d = (rem_d == 14'd0) ? rfhp_pkg::PH_FLAGS : rfhp_pkg::PH_PAY;
      end else begin
        unique case (ph_cur)
          rfhp_pkg::PH_FLAGS: begin
            rel_d   = data_byte_i[7:5];
            split_d = data_byte_i[4];
            len_d   = '0;
            midx_d  = '0;
            oidx_d  = '0;
            och_d   = '0;
            scnt_d  = '0;
            sid_d   = '0;
            sidx_d  = '0;
            rem_d   = '0;
          end
          rfhp_pkg::PH_LEN:  len_d  = {len_q[7:0], data_byte_i};
          rfhp_pkg::PH_MIDX: midx_d = midx_q | 24'({24'd0, data_byte_i} << shamt);
          rfhp_pkg::PH_OIDX: oidx_d = oidx_q | 24'({24'd0, data_byte_i} << shamt);
          rfhp_pkg::PH_OCH:  och_d  = data_byte_i;
          rfhp_pkg::PH_SCNT: scnt_d = {scnt_q[23:0], data_byte_i};
          rfhp_pkg::PH_SID:  sid_d  = {sid_q[7:0], data_byte_i};
          default:           sidx_d = {sidx_q[23:0], data_byte_i};
        endcase
        cnt_d = cnt_inc;
        if (cnt_inc >= rfhp_pkg::section_len(ph_cur)) begin
          cnt_d   = '0;
          phase_d = rfhp_pkg::next_phase(ph_cur, rel_d, split_d);
          if (phase_d == rfhp_pkg::PH_PAY) begin
            len_round                   = {1'b0, len_d} + 17'd7;
            rem_d                       = len_round[16:3];
            entry_o.prim_vld            = 1'b1;
            entry_o.rslt.kind           = rfhp_pkg::KIND_HDR;
            entry_o.rslt.reliability    = rel_d;
            entry_o.rslt.has_split      = split_d;
            entry_o.rslt.payload_length = rem_d;
            entry_o.rslt.message_index  = midx_d;
            entry_o.rslt.order_index    = oidx_d;
            entry_o.rslt.order_channel  = och_d;
            entry_o.rslt.split_count    = scnt_d;
            entry_o.rslt.split_id       = sid_d;
            entry_o.rslt.split_index    = sidx_d;
            if (rem_d == 14'd0) begin
              phase_d = rfhp_pkg::PH_FLAGS;
            end
          end
        end
      end
      if (datagram_end_i && (phase_d != rfhp_pkg::PH_FLAGS)) begin
        entry_o.err = 1'b1;
        phase_d     = rfhp_pkg::PH_FLAGS;
        cnt_d       = '0;
        rem_d       = '0;
      end
    end
  end

  assign push_o = accept && (entry_o.prim_vld || entry_o.err);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rfhp_pkg::PH_FLAGS;
      cnt_q   <= '0;
      rel_q   <= '0;
      split_q <= 1'b0;
      len_q   <= '0;
      midx_q  <= '0;
      oidx_q  <= '0;
      och_q   <= '0;
      scnt_q  <= '0;
      sid_q   <= '0;
      sidx_q  <= '0;
      rem_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      rel_q   <= rel_d;
      split_q <= split_d;
      len_q   <= len_d;
      midx_q  <= midx_d;
      oidx_q  <= oidx_d;
      och_q   <= och_d;
      scnt_q  <= scnt_d;
      sid_q   <= sid_d;
      sidx_q  <= sidx_d;
      rem_q   <= rem_d;
    end
  end

endmodule

// ----- rtl/rfhp_queue.sv -----
// Short queue of result entries between the front end and the back end.
`timescale 1ns / 1ps

module rfhp_queue #(
  parameter int unsigned Depth = rfhp_pkg::RFHP_QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rfhp_pkg::entry_t entry_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             head_vld_o,
  output rfhp_pkg::entry_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rfhp_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign head_vld_o = (count_q != '0);
  assign head_o     = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && head_vld_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- rtl/rfhp_back.sv -----
// Back end: expands queue entries into result items and holds the output register.
`timescale 1ns / 1ps

module rfhp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_vld_i,
  input  rfhp_pkg::entry_t  head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rfhp_pkg::result_t out_o
);

  rfhp_pkg::result_t out_q, out_d;
  logic out_vld_q, out_vld_d;
  logic sub_q, sub_d;
  logic load;

  assign load        = !out_vld_q || out_ready_i;
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  always_comb begin
    out_d     = out_q;
    out_vld_d = out_vld_q && !out_ready_i;
    sub_d     = sub_q;
    pop_o     = 1'b0;
    if (load && head_vld_i) begin
      out_vld_d = 1'b1;
      if (head_i.prim_vld && !sub_q) begin
        out_d = head_i.rslt;
        if (head_i.err) begin
          sub_d = 1'b1;
        end else begin
          pop_o = 1'b1;
        end
      end else begin
        out_d      = '0;
        out_d.kind = rfhp_pkg::KIND_ERR;
        sub_d      = 1'b0;
        pop_o      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      sub_q     <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      sub_q     <= sub_d;
    end
  end

endmodule

// ----- rtl/reliable_frame_header_parser_unit.sv -----
// Top level: frame header parser with decoupled front end, entry queue and back end.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_ready_o   data_byte_i, datagram_end_i
//   out      source     out_valid_o / out_ready_i kind_o .. last_byte_o
//
// One byte is accepted per cycle while the entry queue has room; a byte that causes a result
// and a truncation error yields one entry that leaves as two items, result then error. The
// output register delivers one item per cycle while out_ready_i is high.
// Reset is asynchronous, active low, and clears phase, counters, queue and output valid.
// Output stalls back up through the queue of QUEUE_DEPTH entries before input stalls.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module reliable_frame_header_parser_unit #(
  parameter int unsigned QUEUE_DEPTH = rfhp_pkg::RFHP_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        datagram_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [2:0]  reliability_o,
  output logic        has_split_o,
  output logic [13:0] payload_length_o,
  output logic [23:0] message_index_o,
  output logic [23:0] order_index_o,
  output logic [7:0]  order_channel_o,
  output logic [31:0] split_count_o,
  output logic [15:0] split_id_o,
  output logic [31:0] split_index_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_byte_o
);

  rfhp_pkg::entry_t  push_entry, head_entry;
  rfhp_pkg::result_t rslt;
  rfhp_pkg::phase_e  phase;
  logic push, pop, q_full, head_vld;

  rfhp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .datagram_end_i (datagram_end_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .entry_o        (push_entry),
    .phase_o        (phase)
  );

  rfhp_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .entry_i    (push_entry),
    .pop_i      (pop),
    .full_o     (q_full),
    .head_vld_o (head_vld),
    .head_o     (head_entry)
  );

  rfhp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_vld_i  (head_vld),
    .head_i      (head_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (rslt)
  );

  assign kind_o           = rslt.kind;
  assign reliability_o    = rslt.reliability;
  assign has_split_o      = rslt.has_split;
  assign payload_length_o = rslt.payload_length;
  assign message_index_o  = rslt.message_index;
  assign order_index_o    = rslt.order_index;
  assign order_channel_o  = rslt.order_channel;
  assign split_count_o    = rslt.split_count;
  assign split_id_o       = rslt.split_id;
  assign split_index_o    = rslt.split_index;
  assign payload_byte_o   = rslt.payload_byte;
  assign last_byte_o      = rslt.last_byte;

  `RFHP_ASSERT(a_end_resync, clk_i, rst_ni, in_valid_i && in_ready_o && datagram_end_i |=> phase == rfhp_pkg::PH_FLAGS)
  `RFHP_ASSERT(a_err_clean, clk_i, rst_ni, out_valid_o && kind_o == rfhp_pkg::KIND_ERR |-> payload_byte_o == 8'd0 && last_byte_o == 1'b0 && payload_length_o == 14'd0)
  `RFHP_ASSERT_NEVER(a_push_full, clk_i, rst_ni, push && q_full)
  `RFHP_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop && !head_vld)

endmodule

// ----- dv/testbench.sv -----
// Testbench for the frame header parser: directed frames and random datagrams, checked item by item.
`timescale 1ns / 1ps

module testbench;
  import rfhp_pkg::*;

  localparam int DIR_ROWS = 29;
  localparam int RANDOM_ITEMS = 460;
  localparam int CALM_TAIL = 60;
  localparam int DRAIN_CYCLES = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } dgram_byte_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       typed;
    logic       typed_has_result;
    kind_e      typed_kind;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        datagram_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [2:0]  reliability_o;
  logic        has_split_o;
  logic [13:0] payload_length_o;
  logic [23:0] message_index_o;
  logic [23:0] order_index_o;
  logic [7:0]  order_channel_o;
  logic [31:0] split_count_o;
  logic [15:0] split_id_o;
  logic [31:0] split_index_o;
  logic [7:0]  payload_byte_o;
  logic        last_byte_o;

  reliable_frame_header_parser_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .datagram_end_i   (datagram_end_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .reliability_o    (reliability_o),
    .has_split_o      (has_split_o),
    .payload_length_o (payload_length_o),
    .message_index_o  (message_index_o),
    .order_index_o    (order_index_o),
    .order_channel_o  (order_channel_o),
    .split_count_o    (split_count_o),
    .split_id_o       (split_id_o),
    .split_index_o    (split_index_o),
    .payload_byte_o   (payload_byte_o),
    .last_byte_o      (last_byte_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Parser state mirror
  phase_e      cur_phase = PH_FLAGS;
  int          sect_bytes_seen = 0;
  logic [2:0]  frame_rel = '0;
  logic        frame_split = 1'b0;
  logic [15:0] frame_len_bits = '0;
  logic [23:0] frame_midx = '0;
  logic [23:0] frame_oidx = '0;
  logic [7:0]  frame_och = '0;
  logic [31:0] frame_scnt = '0;
  logic [15:0] frame_sid = '0;
  logic [31:0] frame_sidx = '0;
  logic [13:0] bytes_left = '0;

  result_t step_results[$];
  result_t pending_results[$];

  logic idle_on = 1'b1;
  int   ready_hold = 0;
  int   stall_cycles = 0;
  int   n_faults = 0;
  int   n_in_items = 0;
  int   n_hdr_seen = 0;
  int   n_pay_seen = 0;
  int   n_err_seen = 0;

  function automatic logic section_present(phase_e p);
    case (p)
      PH_MIDX: return frame_rel == 3'd2 || frame_rel == 3'd3 || frame_rel == 3'd4 ||
                      frame_rel == 3'd6 || frame_rel == 3'd7;
      PH_OIDX, PH_OCH: return frame_rel == 3'd1 || frame_rel == 3'd3 || frame_rel == 3'd4 ||
                              frame_rel == 3'd7;
      PH_SCNT, PH_SID, PH_SIDX: return frame_split;
      default: return 1'b1;
    endcase
  endfunction

  function automatic int field_bytes(phase_e p);
    case (p)
      PH_FLAGS, PH_OCH: return 1;
      PH_LEN, PH_SID: return 2;
      PH_MIDX, PH_OIDX: return 3;
      PH_SCNT, PH_SIDX: return 4;
      default: return 0;
    endcase
  endfunction

  function automatic phase_e following_section(phase_e p);
    phase_e n;
    n = phase_e'(p + 4'd1);
    while (n != PH_PAY && !section_present(n)) n = phase_e'(n + 4'd1);
    return n;
  endfunction

  // Advance the mirror by one byte and leave its results in step_results.
  task automatic parse_byte(input logic [7:0] b, input logic e);
    result_t     r;
    phase_e      p;
    logic [16:0] rounded;
    step_results = {};
    p = cur_phase;
    if (p == PH_PAY) begin
      r = '0;
      r.kind = KIND_PAY;
      bytes_left = bytes_left - 14'd1;
      r.payload_byte = b;
      r.last_byte = (bytes_left == 14'd0);
      step_results.insert(step_results.size(), r);
      cur_phase = (bytes_left == 14'd0) ? PH_FLAGS : PH_PAY;
    end else begin
      case (p)
        PH_FLAGS: begin
          frame_rel = b[7:5];
          frame_split = b[4];
          frame_len_bits = '0;
          frame_midx = '0;
          frame_oidx = '0;
          frame_och = '0;
          frame_scnt = '0;
          frame_sid = '0;
          frame_sidx = '0;
          bytes_left = '0;
        end
        PH_LEN:  frame_len_bits = {frame_len_bits[7:0], b};
        PH_MIDX: frame_midx[8*sect_bytes_seen +: 8] = b;
        PH_OIDX: frame_oidx[8*sect_bytes_seen +: 8] = b;
        PH_OCH:  frame_och = b;
        PH_SCNT: frame_scnt = {frame_scnt[23:0], b};
        PH_SID:  frame_sid = {frame_sid[7:0], b};
        default: frame_sidx = {frame_sidx[23:0], b};
      endcase
      sect_bytes_seen++;
      if (sect_bytes_seen >= field_bytes(p)) begin
        sect_bytes_seen = 0;
        p = following_section(p);
        if (p == PH_PAY) begin
          rounded = {1'b0, frame_len_bits} + 17'd7;
          bytes_left = rounded[16:3];
          r = '0;
          r.kind = KIND_HDR;
          r.reliability = frame_rel;
          r.has_split = frame_split;
          r.payload_length = bytes_left;
          r.message_index = frame_midx;
          r.order_index = frame_oidx;
          r.order_channel = frame_och;
          r.split_count = frame_scnt;
          r.split_id = frame_sid;
          r.split_index = frame_sidx;
          step_results.insert(step_results.size(), r);
          if (bytes_left == 14'd0) p = PH_FLAGS;
        end
      end
      cur_phase = p;
    end
    if (e && cur_phase != PH_FLAGS) begin
      r = '0;
      r.kind = KIND_ERR;
      step_results.insert(step_results.size(), r);
      cur_phase = PH_FLAGS;
      sect_bytes_seen = 0;
      bytes_left = '0;
    end
  endtask

  task automatic send_item(input logic [7:0] b, input logic e);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    datagram_end_i <= e;
    do @(posedge clk_i); while (!in_ready_o);
    n_in_items++;
  endtask

  task automatic send_predicted(input logic [7:0] b, input logic e);
    send_item(b, e);
    parse_byte(b, e);
    foreach (step_results[k]) pending_results.insert(pending_results.size(), step_results[k]);
  endtask

  task automatic push_random(inout dgram_byte_t dg[$], input int count);
    logic [7:0] v;
    repeat (count) begin
      v = 8'($urandom);
      dg.insert(dg.size(), {v, 1'b0});
    end
  endtask

  task automatic append_frame(inout dgram_byte_t dg[$]);
    logic [2:0]  rel;
    logic        split;
    logic [3:0]  nib;
    logic [15:0] nbits;
    rel = 3'($urandom_range(0, 7));
    split = ($urandom_range(0, 2) == 0);
    nib = 4'($urandom);
    if ($urandom_range(0, 39) == 0) nbits = 16'($urandom_range(81, 1200));
    else if ($urandom_range(0, 9) == 0) nbits = 16'd0;
    else nbits = 16'($urandom_range(1, 80));
    dg.insert(dg.size(), {rel, split, nib, 1'b0});
    dg.insert(dg.size(), {nbits[15:8], 1'b0});
    dg.insert(dg.size(), {nbits[7:0], 1'b0});
    if (rel == 3'd2 || rel == 3'd3 || rel == 3'd4 || rel == 3'd6 || rel == 3'd7)
      push_random(dg, 3);
    if (rel == 3'd1 || rel == 3'd3 || rel == 3'd4 || rel == 3'd7) push_random(dg, 4);
    if (split) push_random(dg, 10);
    push_random(dg, (int'(nbits) + 7) / 8);
  endtask

  function automatic string fmt_result(result_t r);
    return $sformatf({"kind=%0d rel=%0d split=%0b len=%0d midx=%06h oidx=%06h och=%02h ",
                      "scnt=%08h sid=%04h sidx=%08h byte=%02h last=%0b"},
                     r.kind, r.reliability, r.has_split, r.payload_length, r.message_index,
                     r.order_index, r.order_channel, r.split_count, r.split_id,
                     r.split_index, r.payload_byte, r.last_byte);
  endfunction

  always @(posedge clk_i) begin : rx_side
    result_t got;
    result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = {kind_o, reliability_o, has_split_o, payload_length_o, message_index_o,
               order_index_o, order_channel_o, split_count_o, split_id_o, split_index_o,
               payload_byte_o, last_byte_o};
        if (got.kind == KIND_HDR) n_hdr_seen++;
        else if (got.kind == KIND_PAY) n_pay_seen++;
        else if (got.kind == KIND_ERR) n_err_seen++;
        if (pending_results.size() == 0) begin
          n_faults++;
          if (n_faults <= MAX_REPORTS) $display("%0t unexpected item: %s", $time, fmt_result(got));
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            n_faults++;
            if (n_faults <= MAX_REPORTS) begin
              $display("%0t wrong item", $time);
              $display("  expected %s", fmt_result(want));
              $display("  actual   %s", fmt_result(got));
            end
          end
        end
      end
      if (ready_hold > 0) begin
        ready_hold <= ready_hold - 1;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        ready_hold <= $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    dir_row_t    dir_tab [0:DIR_ROWS-1];
    dgram_byte_t dg[$];
    result_t     r;
    int          random_sent;
    int          mode;
    int          keep;
    logic        drained_once;
    logic [7:0]  v;
    logic        e;
    dir_tab = '{
      {8'h00, 1'b0, 1'b1, 1'b0, KIND_HDR},
      {8'h00, 1'b0, 1'b1, 1'b0, KIND_HDR},
      {8'h00, 1'b1, 1'b1, 1'b1, KIND_HDR},
      {8'hFF, 1'b1, 1'b1, 1'b1, KIND_ERR},
      {8'h60, 1'b0, 1'b0, 1'b0, KIND_HDR},
      {8'hFF, 1'b0, 1'b0, 1'b0, KIND_HDR},
      {8'hFF, 1'b0, 1'b0, 1'b0, KIND_HDR},
      {8'hFF, 1'b0, 1'b0, 1'b0, KIND_HDR},
      {8'hFF, 1'b0, 1'b0, 1'b0, KIND_HDR},
      {8'hFF, 1'b0, 1'b0, 1'b0, KIND_HDR},
      {8'hFF, 1'b0, 1'b0, 1'b0, KIND_HDR},
      {8'hFF, 1'b0, 1'b0, 1'b0, KIND_HDR},
      {8'hFF, 1'b0, 1'b0, 1'b0, KIND_HDR},
      {8'hFF, 1'b0, 1'b0, 1'b0, KIND_HDR},
      {8'hA5, 1'b1, 1'b0, 1'b0, KIND_HDR},
      {8'h1F, 1'b0, 1'b0, 1'b0, KIND_HDR},
      {8'h00, 1'b0, 1'b0, 1'b0, KIND_HDR},
      {8'h01, 1'b0, 1'b0, 1'b0, KIND_HDR},
      {8'hFF, 1'b0, 1'b0, 1'b0, KIND_HDR},
      {8'hFF, 1'b0, 1'b0, 1'b0, KIND_HDR},
      {8'hFF, 1'b0, 1'b0, 1'b0, KIND_HDR},
      {8'hFF, 1'b0, 1'b0, 1'b0, KIND_HDR},
      {8'hFF, 1'b0, 1'b0, 1'b0, KIND_HDR},
      {8'hFF, 1'b0, 1'b0, 1'b0, KIND_HDR},
      {8'h00, 1'b0, 1'b0, 1'b0, KIND_HDR},
      {8'h00, 1'b0, 1'b0, 1'b0, KIND_HDR},
      {8'h00, 1'b0, 1'b0, 1'b0, KIND_HDR},
      {8'h01, 1'b0, 1'b0, 1'b0, KIND_HDR},
      {8'h5A, 1'b1, 1'b0, 1'b0, KIND_HDR}
    };
    random_sent = 0;
    drained_once = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].typed) begin
        send_item(dir_tab[i].value, dir_tab[i].last);
        parse_byte(dir_tab[i].value, dir_tab[i].last);
        if (dir_tab[i].typed_has_result) begin
          r = '0;
          r.kind = dir_tab[i].typed_kind;
          pending_results.insert(pending_results.size(), r);
        end
      end else begin
        send_predicted(dir_tab[i].value, dir_tab[i].last);
      end
    end

    while (random_sent < RANDOM_ITEMS) begin
      dg = {};
      repeat ($urandom_range(1, 3)) append_frame(dg);
      mode = $urandom_range(0, 15);
      if (mode < 2 && dg.size() > 1) begin
        keep = $urandom_range(1, dg.size() - 1);
        while (dg.size() > keep) void'(dg.pop_back());
      end else if (mode == 2) begin
        dg = {};
        repeat ($urandom_range(1, 12)) begin
          v = 8'($urandom);
          e = ($urandom_range(0, 3) == 0);
          dg.insert(dg.size(), {v, e});
        end
      end
      dg[dg.size() - 1].last = 1'b1;
      if (random_sent >= RANDOM_ITEMS - CALM_TAIL) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      if (!drained_once && random_sent >= RANDOM_ITEMS / 2) begin
        drained_once = 1'b1;
        in_valid_i <= 1'b0;
        while (pending_results.size() > 0) @(posedge clk_i);
      end
      foreach (dg[k]) send_predicted(dg[k].value, dg[k].last);
      random_sent += dg.size();
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() > 0) begin
      n_faults += pending_results.size();
      $display("%0d expected items never arrived", pending_results.size());
    end
    $display("sent %0d datagram bytes (%0d random); got %0d headers, %0d payload bytes,",
             n_in_items, random_sent, n_hdr_seen, n_pay_seen);
    $display("%0d truncation errors; %0d faults", n_err_seen, n_faults);
    if (n_faults == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
